// ----- hw/rtl/g7u_pkg.sv -----
// Shared types, constants and character tables of the GSM 7-bit to UTF-8 decoder.
package g7u_pkg;

    localparam logic [7:0] ESC_CODE = 8'h1b;
    localparam logic [7:0] BAD_CHAR = 8'h3f;
    localparam logic [7:0] EURO_B0  = 8'he2;
    localparam logic [7:0] EURO_B1  = 8'h82;
    localparam logic [7:0] EURO_B2  = 8'hac;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // One decoded input item: one to three bytes plus the end-of-string mark.
    typedef struct packed {
        logic [1:0] nbytes;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic       last;
    } g7u_entry_t;

    typedef struct packed {
        logic       hit;
        logic       euro;
        logic [7:0] value;
    } g7u_ext_t;

    // Default alphabet: values below 0x100 are one byte, others high byte then low byte.
    localparam logic [15:0] DEF_MAP [128] = '{
        16'h0040, 16'hc2a3, 16'h0024, 16'hc2a5, 16'hc3a8, 16'hc3a9, 16'hc3b9, 16'hc3ac,
        16'hc3b2, 16'hc387, 16'h000a, 16'hc398, 16'hc3b8, 16'h000d, 16'hc385, 16'hc3a5,
        16'hce94, 16'h005f, 16'hcea6, 16'hce93, 16'hce9b, 16'hcea9, 16'hcea0, 16'hcea8,
        16'hcea3, 16'hce98, 16'hce9e, 16'hc2a0, 16'hc386, 16'hc3a6, 16'hc39f, 16'hc389,
        16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'hc2a4, 16'h0025, 16'h0026, 16'h0027,
        16'h0028, 16'h0029, 16'h002a, 16'h002b, 16'h002c, 16'h002d, 16'h002e, 16'h002f,
        16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
        16'h0038, 16'h0039, 16'h003a, 16'h003b, 16'h003c, 16'h003d, 16'h003e, 16'h003f,
        16'hc2a1, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
        16'h0048, 16'h0049, 16'h004a, 16'h004b, 16'h004c, 16'h004d, 16'h004e, 16'h004f,
        16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
        16'h0058, 16'h0059, 16'h005a, 16'hc384, 16'hc396, 16'hc391, 16'hc39c, 16'hc2a7,
        16'hc2bf, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
        16'h0068, 16'h0069, 16'h006a, 16'h006b, 16'h006c, 16'h006d, 16'h006e, 16'h006f,
        16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
        16'h0078, 16'h0079, 16'h007a, 16'hc3a4, 16'hc3b6, 16'hc3b1, 16'hc3bc, 16'hc3a0
    };

    // Extension table lookup for the code that follows an escape.
    function automatic g7u_ext_t ext_lookup(input logic [7:0] code);
        g7u_ext_t r;
        r.hit   = 1'b1;
        r.euro  = 1'b0;
        r.value = BAD_CHAR;
        unique case (code)
            8'h0a:   r.value = 8'h0c;
            8'h14:   r.value = 8'h5e;
            8'h28:   r.value = 8'h7b;
            8'h29:   r.value = 8'h7d;
            8'h2f:   r.value = 8'h5c;
            8'h3c:   r.value = 8'h5b;
            8'h3d:   r.value = 8'h7e;
            8'h3e:   r.value = 8'h5d;
            8'h40:   r.value = 8'h7c;
            8'h65:   r.euro  = 1'b1;
            default: r.hit   = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/g7u_front.sv -----
// Front end: accepts septets, tracks the escape state and decodes each item into bytes.
module g7u_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [7:0]          septet,
    input  logic                last_in,
    input  logic                q_full,
    output logic                full,
    output logic                q_wr,
    output g7u_pkg::g7u_entry_t q_wr_entry
);
    import g7u_pkg::*;

    logic       esc_reg;
    logic       esc_next;
    logic       accept;
    logic [1:0] plain_n;
    logic [7:0] plain_b0;
    logic [7:0] plain_b1;
    logic       plain_arm;
    logic       run_plain;
    logic [15:0] def_val;
    g7u_ext_t   ext;

    assign full   = q_full;
    assign accept = push && !q_full;
    assign ext    = ext_lookup(septet);
    assign def_val = DEF_MAP[septet[6:0]];

    // Plain decoding, as if no escape were pending.
    always_comb
    begin
        plain_n   = 2'd1;
        plain_b0  = BAD_CHAR;
        plain_b1  = BAD_CHAR;
        plain_arm = 1'b0;
        if (septet[7])
        begin
            plain_n = 2'd1;
        end
        else if (septet == ESC_CODE)
        begin
            if (last_in)
            begin
                plain_n = 2'd1;
            end
            else
            begin
                plain_n   = 2'd0;
                plain_arm = 1'b1;
            end
        end
        else if (def_val[15:8] != 8'h00)
        begin
            plain_n  = 2'd2;
            plain_b0 = def_val[15:8];
            plain_b1 = def_val[7:0];
        end
        else
        begin
            plain_n  = 2'd1;
            plain_b0 = def_val[7:0];
        end
    end

    always_comb
    begin
        run_plain        = 1'b1;
        q_wr_entry.last  = last_in;
        q_wr_entry.nbytes = plain_n;
        q_wr_entry.byte0 = plain_b0;
        q_wr_entry.byte1 = plain_b1;
        q_wr_entry.byte2 = BAD_CHAR;
        if (esc_reg)
        begin
            if (ext.hit && ext.euro)
            begin
                run_plain         = 1'b0;
                q_wr_entry.nbytes = 2'd3;
                q_wr_entry.byte0  = EURO_B0;
                q_wr_entry.byte1  = EURO_B1;
                q_wr_entry.byte2  = EURO_B2;
            end
            else if (ext.hit)
            begin
                run_plain         = 1'b0;
                q_wr_entry.nbytes = 2'd1;
                q_wr_entry.byte0  = ext.value;
            end
            else
            begin
                // Extension miss: '?' for the escape, then the septet itself.
                q_wr_entry.nbytes = plain_n + 2'd1;
                q_wr_entry.byte0  = BAD_CHAR;
                q_wr_entry.byte1  = plain_b0;
                q_wr_entry.byte2  = plain_b1;
            end
        end
    end

    assign q_wr     = accept && (q_wr_entry.nbytes != 2'd0);
    assign esc_next = accept ? (run_plain && plain_arm) : esc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg <= 1'b0;
        end
        else
        begin
            esc_reg <= esc_next;
        end
    end

`ifndef ASSERT_OFF
    a_last_clears_escape: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_in) |=> !esc_reg)
        else $error("escape still pending after the last item of a string");
`endif

endmodule

// ----- hw/rtl/g7u_queue.sv -----
// Short queue of decoded items between the front end and the byte serializer.
module g7u_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  g7u_pkg::g7u_entry_t wr_entry,
    output logic                full,
    input  logic                rd,
    output g7u_pkg::g7u_entry_t rd_entry,
    output logic                nonempty
);
    import g7u_pkg::*;

    g7u_entry_t        mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] wptr_next;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QPTR_W-1:0] rptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_wr;
    logic              do_rd;

    assign full     = (cnt_reg == QCNT_W'(QDEPTH));
    assign nonempty = (cnt_reg != '0);
    assign do_wr    = wr && !full;
    assign do_rd    = rd && nonempty;
    assign rd_entry = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = do_wr ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = do_rd ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr && full))
        else $error("item written into a full queue");
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");
`endif

endmodule

// ----- hw/rtl/g7u_back.sv -----
// Back end: serializes each decoded item into result bytes, one per cycle while pop is high.
module g7u_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_nonempty,
    input  g7u_pkg::g7u_entry_t q_rd_entry,
    output logic                q_rd,
    input  logic                pop,
    output logic                empty,
    output logic [7:0]          utf8_byte,
    output logic                run_end,
    output logic                string_end
);
    import g7u_pkg::*;

    g7u_entry_t cur_reg;
    g7u_entry_t cur_next;
    logic       valid_reg;
    logic       valid_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       taken;

    assign empty      = !valid_reg;
    assign taken      = pop && valid_reg;
    assign run_end    = (idx_reg == cur_reg.nbytes - 2'd1);
    assign string_end = run_end && cur_reg.last;
    assign q_rd       = q_nonempty && (!valid_reg || (taken && run_end));

    always_comb
    begin
        case (idx_reg)
            2'd0:    utf8_byte = cur_reg.byte0;
            2'd1:    utf8_byte = cur_reg.byte1;
            default: utf8_byte = cur_reg.byte2;
        endcase
    end

    always_comb
    begin
        cur_next   = cur_reg;
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (q_rd)
        begin
            cur_next   = q_rd_entry;
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end
        else if (taken)
        begin
            if (run_end)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

`ifndef ASSERT_OFF
    a_nbytes_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (cur_reg.nbytes != 2'd0))
        else $error("serializer holds an item with no bytes");
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (idx_reg < cur_reg.nbytes))
        else $error("byte index past the end of the item");
`endif

endmodule

// ----- hw/rtl/gsm7_to_utf8_decoder.sv -----
// Top level of the GSM 7-bit default alphabet to UTF-8 decoder.
//
//  channel   direction  handshake           fields
//  input     in         push / full         septet[7:0], last_in
//  result    out        pop / empty         utf8_byte[7:0], run_end, string_end
//
// An item is taken in a cycle in which it is pushed while full is low; its
// bytes are queued at that edge and reach the result ports through the
// serializer registers. Each item yields zero to three bytes; the result side
// moves one byte per cycle while pop is high.
// A four-entry queue sits between the decoder and the byte serializer, and full
// rises only when it fills; the input side keeps running while results stall.
// Reset clears the escape state, the queue and the serializer; no clearing pass.
module gsm7_to_utf8_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] septet,
    input  logic       last_in,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] utf8_byte,
    output logic       run_end,
    output logic       string_end
);
    import g7u_pkg::*;

    // Decoded items travel from the front end to the serializer as whole entries.
    g7u_entry_t wr_entry;
    g7u_entry_t rd_entry;
    logic       q_wr;
    logic       q_rd;
    logic       q_full;
    logic       q_nonempty;

    // The front end decodes an item in the cycle it is accepted and tracks
    // whether the previous septet was an escape.
    g7u_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .septet     (septet),
        .last_in    (last_in),
        .q_full     (q_full),
        .full       (full),
        .q_wr       (q_wr),
        .q_wr_entry (wr_entry)
    );

    // Items that produce no bytes (an escape in mid-string) are never queued.
    g7u_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_wr),
        .wr_entry (wr_entry),
        .full     (q_full),
        .rd       (q_rd),
        .rd_entry (rd_entry),
        .nonempty (q_nonempty)
    );

    // The serializer holds the item being sent in registers that drive the
    // result ports directly, and refills from the queue on the last byte.
    g7u_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_rd_entry (rd_entry),
        .q_rd       (q_rd),
        .pop        (pop),
        .empty      (empty),
        .utf8_byte  (utf8_byte),
        .run_end    (run_end),
        .string_end (string_end)
    );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the GSM 7-bit to UTF-8 decoder.
module tb;

    import g7u_pkg::*;

    // One expected byte on the result side, with its two end marks.
    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       string_end;
    } utf8_out_t;

    // One row of the directed table. When typed is set, count and bytes hold the
    // result read straight off the character tables; the first byte sits in the
    // top eight bits. Other rows are checked against the decoder model below.
    typedef struct packed {
        logic [7:0]  code;
        logic        last;
        logic        typed;
        logic [1:0]  count;
        logic [23:0] bytes;
    } septet_row_t;

    // Default alphabet, written out independently of the design: values below
    // 0x100 are single bytes, others are a lead byte followed by a trail byte.
    localparam logic [15:0] GSM_DEFAULT [128] = '{
        16'h0040, 16'hc2a3, 16'h0024, 16'hc2a5, 16'hc3a8, 16'hc3a9, 16'hc3b9, 16'hc3ac,
        16'hc3b2, 16'hc387, 16'h000a, 16'hc398, 16'hc3b8, 16'h000d, 16'hc385, 16'hc3a5,
        16'hce94, 16'h005f, 16'hcea6, 16'hce93, 16'hce9b, 16'hcea9, 16'hcea0, 16'hcea8,
        16'hcea3, 16'hce98, 16'hce9e, 16'hc2a0, 16'hc386, 16'hc3a6, 16'hc39f, 16'hc389,
        16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'hc2a4, 16'h0025, 16'h0026, 16'h0027,
        16'h0028, 16'h0029, 16'h002a, 16'h002b, 16'h002c, 16'h002d, 16'h002e, 16'h002f,
        16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
        16'h0038, 16'h0039, 16'h003a, 16'h003b, 16'h003c, 16'h003d, 16'h003e, 16'h003f,
        16'hc2a1, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
        16'h0048, 16'h0049, 16'h004a, 16'h004b, 16'h004c, 16'h004d, 16'h004e, 16'h004f,
        16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
        16'h0058, 16'h0059, 16'h005a, 16'hc384, 16'hc396, 16'hc391, 16'hc39c, 16'hc2a7,
        16'hc2bf, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
        16'h0068, 16'h0069, 16'h006a, 16'h006b, 16'h006c, 16'h006d, 16'h006e, 16'h006f,
        16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
        16'h0078, 16'h0079, 16'h007a, 16'hc3a4, 16'hc3b6, 16'hc3b1, 16'hc3bc, 16'hc3a0
    };

    // Codes that hit the extension table after an escape; the last one is the euro sign.
    localparam logic [7:0] EXT_CODES [10] = '{
        8'h0a, 8'h14, 8'h28, 8'h29, 8'h2f, 8'h3c, 8'h3d, 8'h3e, 8'h40, 8'h65
    };
    localparam logic [7:0] EURO_CODE = 8'h65;

    // Directed part: table extremes, invalid codes, every kind of escape outcome
    // and the escape at the end of a string, alone and after another escape.
    localparam int DIR_ROWS = 24;
    localparam septet_row_t DIRECTED [DIR_ROWS] = '{
        '{8'h00,    1'b0, 1'b1, 2'd1, 24'h400000},  // first code after reset
        '{8'h7f,    1'b0, 1'b1, 2'd2, 24'hc3a000},  // top of the default table
        '{8'h80,    1'b0, 1'b1, 2'd1, 24'h3f0000},  // lowest invalid code
        '{8'hff,    1'b0, 1'b1, 2'd1, 24'h3f0000},  // highest invalid code
        '{8'h01,    1'b0, 1'b1, 2'd2, 24'hc2a300},
        '{ESC_CODE, 1'b0, 1'b1, 2'd0, 24'h000000},  // escape alone yields nothing
        '{8'h65,    1'b0, 1'b1, 2'd3, 24'he282ac},  // euro sign
        '{ESC_CODE, 1'b0, 1'b1, 2'd0, 24'h000000},
        '{8'h28,    1'b0, 1'b1, 2'd1, 24'h7b0000},
        '{ESC_CODE, 1'b0, 1'b1, 2'd0, 24'h000000},
        '{8'h41,    1'b0, 1'b1, 2'd2, 24'h3f4100},  // extension miss, then plain
        '{ESC_CODE, 1'b0, 1'b1, 2'd0, 24'h000000},
        '{ESC_CODE, 1'b0, 1'b1, 2'd1, 24'h3f0000},  // miss that arms a new escape
        '{8'h0a,    1'b0, 1'b1, 2'd1, 24'h0c0000},
        '{ESC_CODE, 1'b0, 1'b1, 2'd0, 24'h000000},
        '{8'h80,    1'b0, 1'b1, 2'd2, 24'h3f3f00},  // miss on an invalid code
        '{ESC_CODE, 1'b1, 1'b1, 2'd1, 24'h3f0000},  // escape closing a string
        '{ESC_CODE, 1'b0, 1'b1, 2'd0, 24'h000000},
        '{ESC_CODE, 1'b1, 1'b1, 2'd2, 24'h3f3f00},  // two escapes closing a string
        '{ESC_CODE, 1'b0, 1'b0, 2'd0, 24'h000000},
        '{8'h05,    1'b0, 1'b0, 2'd0, 24'h000000},  // miss followed by two bytes
        '{ESC_CODE, 1'b0, 1'b0, 2'd0, 24'h000000},
        '{8'h40,    1'b0, 1'b0, 2'd0, 24'h000000},
        '{8'h20,    1'b1, 1'b1, 2'd1, 24'h200000}
    };

    localparam int RANDOM_ITEMS = 126;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] septet;
    logic       last_in;
    logic       pop = 1'b0;
    logic       empty;
    logic [7:0] utf8_byte;
    logic       run_end;
    logic       string_end;

    // Model state: escape flag and the bytes produced by the item just decoded.
    logic       escape_armed = 1'b0;
    logic [7:0] decoded_bytes [$];

    // Bytes the block still owes, oldest first.
    utf8_out_t  pending_bytes [$];
    utf8_out_t  want;
    int         failures = 0;

    // Sender pacing: items left in the current burst.
    int         burst_left = 0;

    // Receiver pacing.
    int         pop_cycle = 0;
    int         pop_mode = 0;

    gsm7_to_utf8_decoder DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .septet     (septet),
        .last_in    (last_in),
        .pop        (pop),
        .empty      (empty),
        .utf8_byte  (utf8_byte),
        .run_end    (run_end),
        .string_end (string_end)
    );

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Append one byte to the output of the item being decoded.
    function automatic void add_decoded(input logic [7:0] b);
        decoded_bytes.insert(decoded_bytes.size(), b);
    endfunction

    // Decode a septet as if no escape were pending.
    function automatic void decode_plain(input logic [7:0] code, input logic last);
        logic [15:0] glyph;
        if (code[7])
        begin
            add_decoded(BAD_CHAR);
        end
        else if (code == ESC_CODE)
        begin
            // An escape cannot be left dangling at the end of a string.
            if (last)
                add_decoded(BAD_CHAR);
            else
                escape_armed = 1'b1;
        end
        else
        begin
            glyph = GSM_DEFAULT[code[6:0]];
            if (glyph[15:8] != 8'h00)
                add_decoded(glyph[15:8]);
            add_decoded(glyph[7:0]);
        end
    endfunction

    // Decode one septet into decoded_bytes, updating the escape flag.
    function automatic void decode_septet(input logic [7:0] code, input logic last);
        logic [7:0] ext_char;
        logic       ext_hit;
        decoded_bytes.delete();
        if (!escape_armed)
        begin
            decode_plain(code, last);
            return;
        end
        escape_armed = 1'b0;
        ext_hit = 1'b1;
        ext_char = BAD_CHAR;
        case (code)
            8'h0a:   ext_char = 8'h0c;
            8'h14:   ext_char = 8'h5e;
            8'h28:   ext_char = 8'h7b;
            8'h29:   ext_char = 8'h7d;
            8'h2f:   ext_char = 8'h5c;
            8'h3c:   ext_char = 8'h5b;
            8'h3d:   ext_char = 8'h7e;
            8'h3e:   ext_char = 8'h5d;
            8'h40:   ext_char = 8'h7c;
            default: ext_hit = 1'b0;
        endcase
        if (code == EURO_CODE)
        begin
            add_decoded(EURO_B0);
            add_decoded(EURO_B1);
            add_decoded(EURO_B2);
        end
        else if (ext_hit)
        begin
            add_decoded(ext_char);
        end
        else
        begin
            // The escape itself becomes '?', then the code is taken as plain.
            add_decoded(BAD_CHAR);
            decode_plain(code, last);
        end
    endfunction

    // Present one item and hold it until the block takes it. At the accepting
    // edge the owed bytes are queued, either typed in from the table or from
    // the model; the model runs in both cases so the escape flag stays in step.
    // Afterwards, at the end of a burst, the sender drops push for a random gap.
    task automatic send_septet(input logic [7:0] code, input logic last,
                               input logic typed, input logic [1:0] count,
                               input logic [23:0] bytes);
        utf8_out_t entry;
        int        gap;
        septet  <= code;
        last_in <= last;
        push    <= 1'b1;
        do
            @(posedge clk);
        while (full);
        decode_septet(code, last);
        if (typed)
        begin
            decoded_bytes.delete();
            for (int k = 0; k < count; k++)
                add_decoded(bytes[23 - 8*k -: 8]);
        end
        for (int k = 0; k < decoded_bytes.size(); k++)
        begin
            entry.data       = decoded_bytes[k];
            entry.run_end    = (k == decoded_bytes.size() - 1);
            entry.string_end = entry.run_end && last;
            pending_bytes.insert(pending_bytes.size(), entry);
        end
        if (burst_left == 0)
        begin
            // End of a burst: drop push for a random gap, then pick the next burst.
            gap = $urandom_range(1, 6);
            burst_left = $urandom_range(0, 15);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        else
        begin
            burst_left--;
        end
    endtask

    // Stop sending until every owed byte has come out.
    task automatic wait_drained();
        push <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
    endtask

    // The receiver periodically picks a new pop pattern at random: always ready,
    // every other cycle, randomly about 60 percent, or one cycle in five.
    always @(posedge clk)
    begin
        pop_cycle++;
        if (pop_cycle % 97 == 0)
            pop_mode = $urandom_range(0, 3);
        case (pop_mode)
            0:       pop <= 1'b1;
            1:       pop <= pop_cycle[0];
            2:       pop <= ($urandom_range(0, 9) < 6);
            default: pop <= (pop_cycle % 5 == 0);
        endcase
    end

    // Every byte the receiver takes is compared against the oldest owed byte.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_bytes.size() == 0)
            begin
                $error("unexpected byte: utf8_byte=%h run_end=%b string_end=%b",
                       utf8_byte, run_end, string_end);
                failures++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (utf8_byte !== want.data)
                begin
                    $error("utf8_byte: expected %h, actual %h", want.data, utf8_byte);
                    failures++;
                end
                if (run_end !== want.run_end)
                begin
                    $error("run_end: expected %b, actual %b", want.run_end, run_end);
                    failures++;
                end
                if (string_end !== want.string_end)
                begin
                    $error("string_end: expected %b, actual %b",
                           want.string_end, string_end);
                    failures++;
                end
            end
        end
    end

    // Main sequence: reset, the directed table, a full drain, then random
    // strings, and finally a drain with a short tail for stray output.
    initial
    begin
        logic [7:0] text [$];
        int         sent;
        int         len;
        int         style;
        push    = 1'b0;
        septet  = 8'h00;
        last_in = 1'b0;
        rst_n   = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
            send_septet(DIRECTED[r].code, DIRECTED[r].last, DIRECTED[r].typed,
                        DIRECTED[r].count, DIRECTED[r].bytes);

        // Hold off entirely until the directed bytes are all out.
        wait_drained();

        // Random strings. Most are well formed: plain characters mixed with
        // escape pairs that hit the extension table. The rest are noise with
        // invalid codes and loose escapes, and any string may be made to end on an escape.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            text.delete();
            len = $urandom_range(1, 10);
            style = $urandom_range(0, 9);
            while (text.size() < len)
            begin
                if (style < 7)
                begin
                    if ($urandom_range(0, 3) == 0 && text.size() + 1 < len)
                    begin
                        text.insert(text.size(), ESC_CODE);
                        text.insert(text.size(), EXT_CODES[$urandom_range(0, 9)]);
                    end
                    else
                    begin
                        text.insert(text.size(), 8'($urandom_range(0, 127)));
                    end
                end
                else if ($urandom_range(0, 3) == 0)
                begin
                    text.insert(text.size(), ESC_CODE);
                end
                else
                begin
                    text.insert(text.size(), 8'($urandom_range(0, 255)));
                end
            end
            if ($urandom_range(0, 7) == 0)
                text[text.size() - 1] = ESC_CODE;
            for (int k = 0; k < text.size(); k++)
                send_septet(text[k], k == text.size() - 1, 1'b0, 2'd0, 24'h000000);
            sent += text.size();
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (12) @(posedge clk);
        if (failures == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Watchdog: ends the run with a failure if the main sequence hangs.
    initial
    begin
        #400000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/g7u_pkg.sv
hw/rtl/g7u_front.sv
hw/rtl/g7u_queue.sv
hw/rtl/g7u_back.sv
hw/rtl/gsm7_to_utf8_decoder.sv
tb/tb.sv
